// File: sv/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and calendar helpers for the date adjust block.
// ----------------------------------------------------------------------------
package cda_pkg;

	// working widths of the normalization registers
	localparam int D_W = 17;
	localparam int M_W = 17;
	localparam int Y_W = 18;

	// residue of the year within the leap cycle
	localparam int R_W = 9;

	localparam int MONTHS     = 12;
	localparam int YEAR_MAX   = 9999;
	localparam int YEAR_MIN   = 1;
	localparam int LEAP_CYCLE = 400;

	// input op codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	// year clamp codes
	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_HIGH = 2'd1;
	localparam logic [1:0] CLAMP_LOW  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_MONTH,
		ST_DAYUP,
		ST_DAYDN,
		ST_CLAMP,
		ST_DONE
	} cda_state_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [1:0]  clamp;
	} date_res_t;

	// leap test on the year residue modulo 400
	function automatic logic is_leap(input logic [R_W-1:0] res);
		logic century;
		century = (res == R_W'(100)) || (res == R_W'(200)) || (res == R_W'(300));
		return (res[1:0] == 2'b00) && !century;
	endfunction

	// month length, month already in 1..12
	function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

endpackage

// File: sv/calendar_date_adjust.sv
// ----------------------------------------------------------------------------
// calendar_date_adjust
// Keeps a Gregorian date; loads it or adds signed day/month/year amounts.
// ----------------------------------------------------------------------------
// sequence: after accept the core runs ST_MOD (leap-cycle reduction steps), ST_MONTH
//   (months carried), ST_DAYUP and ST_DAYDN (months walked by the day loop),
//   ST_CLAMP and ST_DONE; the result then passes to the output register
// one item at a time; the shared adder takes one step a cycle
// reset: stored date clears to zero (unset), no item in flight, output empty
// ----------------------------------------------------------------------------
module calendar_date_adjust (
	input  logic               clk,
	input  logic               arst_n,
	// input item channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic signed [15:0] day_amount,
	input  logic signed [15:0] month_amount,
	input  logic signed [14:0] year_amount,
	// result item channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         day_out,
	output logic [3:0]         month_out,
	output logic [13:0]        year_out,
	output logic [1:0]         year_clamped
);

	logic               core_start;
	logic               core_busy;
	logic               core_res_valid;
	logic               core_res_take;
	cda_pkg::date_res_t core_res;

	logic               out_valid_q;
	cda_pkg::date_res_t out_q;

	// an item is taken whenever the sequencer is idle; a finished result
	// waiting in the output register does not hold up the next item
	assign in_stall   = core_busy;
	assign core_start = in_valid && !in_stall;

	cda_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (core_start),
		.op           (op),
		.day_amount   (day_amount),
		.month_amount (month_amount),
		.year_amount  (year_amount),
		.busy         (core_busy),
		.res_valid    (core_res_valid),
		.res_take     (core_res_take),
		.res          (core_res)
	);

	// output register frees when empty or when its item leaves this cycle
	assign core_res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_take) begin
			out_valid_q <= core_res_valid;
		end
	end

	// payload only moves when the register is free
	always_ff @(posedge clk) begin
		if (core_res_take && core_res_valid) begin
			out_q <= core_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign day_out      = out_q.day;
	assign month_out    = out_q.month;
	assign year_out     = out_q.year;
	assign year_clamped = out_q.clamp;

endmodule

// File: sv/cda_core.sv
// ----------------------------------------------------------------------------
// cda_core
// Iterative date normalizer: one shared adder stepped by a small sequencer.
// ----------------------------------------------------------------------------
module cda_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    op,
	input  logic signed [15:0]      day_amount,
	input  logic signed [15:0]      month_amount,
	input  logic signed [14:0]      year_amount,
	output logic                    busy,
	output logic                    res_valid,
	input  logic                    res_take,
	output cda_pkg::date_res_t      res
);

	localparam int D_W = cda_pkg::D_W;
	localparam int M_W = cda_pkg::M_W;
	localparam int Y_W = cda_pkg::Y_W;
	localparam int R_W = cda_pkg::R_W;

	cda_pkg::cda_state_t state_q, state_n;

	// working date; holds the stored date between items
	logic signed [D_W-1:0] d_q, d_n;
	logic signed [M_W-1:0] m_q, m_n;
	logic signed [Y_W-1:0] y_q, y_n;
	// year residue modulo 400, tracked alongside y
	logic signed [Y_W-1:0] r_q, r_n;
	logic [1:0]            flag_q, flag_n;

	// shared adder
	logic signed [Y_W-1:0] alu_a, alu_b, alu_sum;

	logic signed [Y_W-1:0] r_inc, r_dec, r_prev;
	logic [3:0]            m_lo, m_prev;
	logic [4:0]            dim_cur, dim_prev, dim_clamp;
	logic                  leap_clamp;

	assign alu_sum = alu_a + alu_b;

	assign r_inc  = (r_q[R_W-1:0] == R_W'(cda_pkg::LEAP_CYCLE - 1)) ? '0 : r_q + Y_W'(1);
	assign r_dec  = (r_q[R_W-1:0] == '0) ? Y_W'(cda_pkg::LEAP_CYCLE - 1) : r_q - Y_W'(1);
	assign m_lo   = m_q[3:0];
	assign m_prev = (m_lo == 4'd1) ? 4'(cda_pkg::MONTHS) : m_lo - 4'd1;
	assign r_prev = (m_lo == 4'd1) ? r_dec : r_q;

	assign dim_cur  = cda_pkg::days_in(m_lo, cda_pkg::is_leap(r_q[R_W-1:0]));
	assign dim_prev = cda_pkg::days_in(m_prev, cda_pkg::is_leap(r_prev[R_W-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cda_pkg::ST_IDLE;
			d_q     <= '0;
			m_q     <= '0;
			y_q     <= '0;
		end else begin
			state_q <= state_n;
			d_q     <= d_n;
			m_q     <= m_n;
			y_q     <= y_n;
		end
	end

	always_ff @(posedge clk) begin
		r_q    <= r_n;
		flag_q <= flag_n;
	end

	always_comb begin
		state_n    = state_q;
		d_n        = d_q;
		m_n        = m_q;
		y_n        = y_q;
		r_n        = r_q;
		flag_n     = flag_q;
		alu_a      = '0;
		alu_b      = '0;
		leap_clamp = 1'b0;
		dim_clamp  = dim_cur;
		unique case (state_q)
			cda_pkg::ST_IDLE: begin
				if (start) begin
					if (op == cda_pkg::OP_ADD) begin
						d_n = D_W'(day_amount) + d_q;
						m_n = M_W'(month_amount) + m_q;
						y_n = Y_W'(year_amount) + y_q;
					end else begin
						d_n = D_W'(day_amount);
						m_n = M_W'(month_amount);
						y_n = Y_W'(year_amount);
					end
					r_n     = y_n;
					state_n = cda_pkg::ST_MOD;
				end
			end
			cda_pkg::ST_MOD: begin
				// bring the residue into 0..399, one cycle length a step
				alu_a = r_q;
				if (r_q >= Y_W'(cda_pkg::LEAP_CYCLE)) begin
					alu_b = -Y_W'(cda_pkg::LEAP_CYCLE);
					r_n   = alu_sum;
				end else if (r_q < 0) begin
					alu_b = Y_W'(cda_pkg::LEAP_CYCLE);
					r_n   = alu_sum;
				end else begin
					state_n = cda_pkg::ST_MONTH;
				end
			end
			cda_pkg::ST_MONTH: begin
				// month carry into years, one year a step
				alu_a = Y_W'(m_q);
				if (m_q > M_W'(cda_pkg::MONTHS)) begin
					alu_b = -Y_W'(cda_pkg::MONTHS);
					m_n   = alu_sum[M_W-1:0];
					y_n   = y_q + Y_W'(1);
					r_n   = r_inc;
				end else if (m_q < M_W'(1)) begin
					alu_b = Y_W'(cda_pkg::MONTHS);
					m_n   = alu_sum[M_W-1:0];
					y_n   = y_q - Y_W'(1);
					r_n   = r_dec;
				end else begin
					state_n = cda_pkg::ST_DAYUP;
				end
			end
			cda_pkg::ST_DAYUP: begin
				// day carry, one month a step; signed compare so a negative day falls through
				alu_a = Y_W'(d_q);
				if (d_q > signed'(D_W'(dim_cur))) begin
					alu_b = -Y_W'(dim_cur);
					d_n   = alu_sum[D_W-1:0];
					if (m_lo == 4'(cda_pkg::MONTHS)) begin
						m_n = M_W'(1);
						y_n = y_q + Y_W'(1);
						r_n = r_inc;
					end else begin
						m_n = m_q + M_W'(1);
					end
				end else begin
					state_n = cda_pkg::ST_DAYDN;
				end
			end
			cda_pkg::ST_DAYDN: begin
				// day borrow, previous month length a step
				alu_a = Y_W'(d_q);
				if (d_q <= 0) begin
					alu_b = Y_W'(dim_prev);
					d_n   = alu_sum[D_W-1:0];
					m_n   = M_W'(m_prev);
					if (m_lo == 4'd1) begin
						y_n = y_q - Y_W'(1);
						r_n = r_dec;
					end
				end else begin
					state_n = cda_pkg::ST_CLAMP;
				end
			end
			cda_pkg::ST_CLAMP: begin
				if (y_q > Y_W'(cda_pkg::YEAR_MAX)) begin
					y_n    = Y_W'(cda_pkg::YEAR_MAX);
					flag_n = cda_pkg::CLAMP_HIGH;
				end else if (y_q < Y_W'(cda_pkg::YEAR_MIN)) begin
					y_n    = Y_W'(cda_pkg::YEAR_MIN);
					flag_n = cda_pkg::CLAMP_LOW;
				end else begin
					flag_n     = cda_pkg::CLAMP_NONE;
					leap_clamp = cda_pkg::is_leap(r_q[R_W-1:0]);
				end
				// both clamp years are common years
				dim_clamp = cda_pkg::days_in(m_lo, leap_clamp);
				if (d_q > D_W'(dim_clamp)) begin
					d_n = D_W'(1);
					m_n = m_q + M_W'(1);
				end
				state_n = cda_pkg::ST_DONE;
			end
			cda_pkg::ST_DONE: begin
				if (res_take) begin
					state_n = cda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = cda_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy      = (state_q != cda_pkg::ST_IDLE);
	assign res_valid = (state_q == cda_pkg::ST_DONE);

	assign res.day   = d_q[4:0];
	assign res.month = m_q[3:0];
	assign res.year  = y_q[13:0];
	assign res.clamp = flag_q;

endmodule

// File: sv/cda_checker.sv
// ----------------------------------------------------------------------------
// cda_checker
// Port-level checks on the date adjust block, bound to its top level.
// ----------------------------------------------------------------------------
module cda_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [4:0]         day_out,
	input logic [3:0]         month_out,
	input logic [13:0]        year_out,
	input logic [1:0]         year_clamped
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(day_out) && $stable(month_out)
			&& $stable(year_out) && $stable(year_clamped))
		else $error("stalled result changed");

	// an accepted item keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting an item");

	// result date lies in range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> day_out >= 5'd1 && day_out <= 5'd31 && month_out >= 4'd1
			&& month_out <= 4'd12 && year_out >= 14'(cda_pkg::YEAR_MIN)
			&& year_out <= 14'(cda_pkg::YEAR_MAX))
		else $error("result date out of range");

	// clamp flag agrees with the year
	a_clamp_year: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (year_clamped == cda_pkg::CLAMP_NONE)
			|| (year_clamped == cda_pkg::CLAMP_HIGH && year_out == 14'(cda_pkg::YEAR_MAX))
			|| (year_clamped == cda_pkg::CLAMP_LOW && year_out == 14'(cda_pkg::YEAR_MIN)))
		else $error("clamp flag does not match year");

endmodule

bind calendar_date_adjust cda_checker u_cda_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.day_out      (day_out),
	.month_out    (month_out),
	.year_out     (year_out),
	.year_clamped (year_clamped)
);
